### rtl/core/ntg_pkg.sv
// Shared types and constants for the synthetic traffic generator.
package ntg_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int NODE_ID_W  = 6;
    localparam int ADDR_W     = 12;
    localparam int STALL_W    = 16;
    localparam int COUNT_W    = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_ID        = 3'd0,
        CFG_PATTERN        = 3'd1,
        CFG_FIXED_DEST     = 3'd2,
        CFG_ONLY_SENDER    = 3'd3,
        CFG_MAX_PACKETS    = 3'd4,
        CFG_INJ_THRESHOLD  = 3'd5,
        CFG_VNET_CHOICE    = 3'd6,
        CFG_STALL_LIMIT    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PAT_UNIFORM    = 3'd0,
        PAT_COMPLEMENT = 3'd1,
        PAT_REVERSE    = 3'd2,
        PAT_ROTATION   = 3'd3,
        PAT_NEIGHBOR   = 3'd4,
        PAT_SHUFFLE    = 3'd5,
        PAT_TRANSPOSE  = 3'd6,
        PAT_TORNADO    = 3'd7
    } pattern_t;

    localparam logic [1:0] VNET_WRITE  = 2'd2;
    localparam logic [1:0] VNET_RANDOM = 2'd3;

    typedef struct packed {
        logic [NODE_ID_W-1:0] node_id;
        pattern_t             pattern;
        logic signed [6:0]    fixed_dest;
        logic signed [6:0]    only_sender;
        logic signed [31:0]   max_packets;
        logic [16:0]          inj_threshold;
        logic [1:0]           vnet_choice;
        logic [STALL_W-1:0]   stall_limit;
    } cfg_t;

    typedef struct packed {
        logic        retry_pending;
        logic        response_seen;
        logic [1:0]  rand_vnet;
        logic [5:0]  rand_dest;
        logic [15:0] rand_inject;
    } in_item_t;

    typedef struct packed {
        logic send;
        logic deadlock;
    } ctrl_flags_t;

endpackage

### rtl/core/ntg_dest_sel.sv
// Destination selection by fixed destination or spatial traffic pattern.
module ntg_dest_sel #(
    parameter int RADIX_LOG2 = 3,
    parameter int DEST_W     = 6
) (
    input  logic [ntg_pkg::NODE_ID_W-1:0] node_id,
    input  ntg_pkg::pattern_t             pattern,
    input  logic signed [6:0]             fixed_dest,
    input  logic [5:0]                    rand_dest,
    output logic [DEST_W-1:0]             dest
);

    localparam int NODE_W = 2 * RADIX_LOG2;
    localparam int RADIX  = 1 << RADIX_LOG2;
    localparam logic [RADIX_LOG2-1:0] TORNADO_STEP = RADIX_LOG2'(RADIX / 2 - 1);

    logic [DEST_W-1:0]     node_ext;
    logic [DEST_W-1:0]     rand_ext;
    logic [NODE_W-1:0]     src;
    logic [NODE_W-1:0]     rev;
    logic [NODE_W-1:0]     pat_dest;
    logic [RADIX_LOG2-1:0] x;
    logic [RADIX_LOG2-1:0] y;

    assign node_ext = DEST_W'(node_id);
    assign rand_ext = DEST_W'(rand_dest);
    assign src      = node_ext[NODE_W-1:0];
    assign x        = src[RADIX_LOG2-1:0];
    assign y        = src[NODE_W-1:RADIX_LOG2];

    always_comb begin
        for (int i = 0; i < NODE_W; i++) begin
            rev[NODE_W-1-i] = src[i];
        end
    end

    always_comb begin
        case (pattern)
            ntg_pkg::PAT_UNIFORM:    pat_dest = rand_ext[NODE_W-1:0];
            ntg_pkg::PAT_COMPLEMENT: pat_dest = ~src;
            ntg_pkg::PAT_REVERSE:    pat_dest = rev;
            ntg_pkg::PAT_ROTATION:   pat_dest = {src[0], src[NODE_W-1:1]};
            ntg_pkg::PAT_NEIGHBOR:   pat_dest = {y, x + RADIX_LOG2'(1)};
            ntg_pkg::PAT_SHUFFLE:    pat_dest = {src[NODE_W-2:0], src[NODE_W-1]};
            ntg_pkg::PAT_TRANSPOSE:  pat_dest = {x, y};
            default:                 pat_dest = {y, x + TORNADO_STEP};
        endcase
    end

    assign dest = fixed_dest[6] ? DEST_W'(pat_dest) : DEST_W'(fixed_dest[5:0]);

endmodule

### rtl/core/ntg_ctrl.sv
// Injection decision, packet cap, sender gate and stall/deadlock tracking.
module ntg_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ntg_pkg::cfg_t         cfg,
    input  ntg_pkg::in_item_t     item,
    input  logic                  advance,
    output ntg_pkg::ctrl_flags_t  flags
);

    logic [ntg_pkg::COUNT_W-1:0] sent_count_reg;
    logic [ntg_pkg::COUNT_W-1:0] sent_count_next;
    logic [ntg_pkg::STALL_W-1:0] stall_reg;
    logic [ntg_pkg::STALL_W-1:0] stall_next;
    logic [ntg_pkg::STALL_W-1:0] stall_base;
    logic                        rate_ok;
    logic                        cap_hit;
    logic                        gate_block;

    always_comb begin
        stall_base = item.response_seen ? '0 : stall_reg;
        stall_next = stall_base;
        if (item.retry_pending && (stall_base != {ntg_pkg::STALL_W{1'b1}})) begin
            stall_next = stall_base + ntg_pkg::STALL_W'(1);
        end
    end

    assign rate_ok    = {1'b0, item.rand_inject} < cfg.inj_threshold;
    assign cap_hit    = !cfg.max_packets[31] &&
                        (sent_count_reg >= ntg_pkg::COUNT_W'(cfg.max_packets));
    assign gate_block = !cfg.only_sender[6] &&
                        (cfg.node_id != cfg.only_sender[5:0]);

    assign flags.send     = rate_ok && !cap_hit && !gate_block;
    assign flags.deadlock = item.retry_pending && (stall_next >= cfg.stall_limit);

    always_comb begin
        sent_count_next = sent_count_reg;
        if (flags.send && (sent_count_reg != {ntg_pkg::COUNT_W{1'b1}})) begin
            sent_count_next = sent_count_reg + ntg_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_count_reg <= '0;
            stall_reg      <= '0;
        end else if (advance) begin
            sent_count_reg <= sent_count_next;
            stall_reg      <= stall_next;
        end
    end

endmodule

### rtl/core/noc_synthetic_traffic_generator_top.sv
// Top level of the mesh-node synthetic traffic generator.
// Each accepted transaction is one network clock tick for this node and yields exactly one
// result transaction. The block takes one transaction per cycle unless m_tready stalls it;
// the result passes through the input register, then the result register, with the
// injection decision, destination pattern and stall counter all resolved in the single
// logic level between them. Backpressure on m_tready holds both registers; a new transaction
// is still taken while a result waits, as long as the input register is free. Write
// configuration only while no transaction is in flight. Unsent ticks report zero
// destination, vnet and address; deadlock is a level flag and never stops injection.
module noc_synthetic_traffic_generator_top #(
    parameter int RADIX_LOG2 = 3,
    parameter int ADDR_SHIFT = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ntg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rand_inject[15:0], rand_dest[21:16], rand_vnet[23:22], response_seen[24],
    // retry_pending[25], zero[31:26]
    input  logic [ntg_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // send[0], dest_node[6:1], vnet[8:7], packet_addr[20:9], deadlock[21], zero[23:22]
    output logic [ntg_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int NODE_W = 2 * RADIX_LOG2;
    localparam int DEST_W = (NODE_W > 6) ? NODE_W : 6;
    localparam int SHIFT_W = DEST_W + ntg_pkg::ADDR_W;

    ntg_pkg::cfg_t          cfg_reg;
    ntg_pkg::in_item_t      item_reg;
    logic                   item_valid_reg;
    logic                   m_valid_reg;
    logic [ntg_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [ntg_pkg::M_TDATA_W-1:0] m_data_next;

    ntg_pkg::ctrl_flags_t   flags;
    logic [DEST_W-1:0]      dest;
    logic [SHIFT_W-1:0]     addr_wide;
    logic [1:0]             vnet_sel;
    logic                   out_free;
    logic                   advance;
    logic                   s_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id        <= '0;
            cfg_reg.pattern        <= ntg_pkg::PAT_UNIFORM;
            cfg_reg.fixed_dest     <= '1;
            cfg_reg.only_sender    <= '1;
            cfg_reg.max_packets    <= '1;
            cfg_reg.inj_threshold  <= 17'd6554;
            cfg_reg.vnet_choice    <= ntg_pkg::VNET_RANDOM;
            cfg_reg.stall_limit    <= 16'd5000;
        end else if (cfg_we) begin
            unique case (ntg_pkg::cfg_idx_t'(cfg_index))
                ntg_pkg::CFG_NODE_ID:        cfg_reg.node_id <= cfg_wdata[5:0];
                ntg_pkg::CFG_PATTERN:
                    cfg_reg.pattern <= ntg_pkg::pattern_t'(cfg_wdata[2:0]);
                ntg_pkg::CFG_FIXED_DEST:     cfg_reg.fixed_dest <= cfg_wdata[6:0];
                ntg_pkg::CFG_ONLY_SENDER:    cfg_reg.only_sender <= cfg_wdata[6:0];
                ntg_pkg::CFG_MAX_PACKETS:    cfg_reg.max_packets <= cfg_wdata;
                ntg_pkg::CFG_INJ_THRESHOLD:  cfg_reg.inj_threshold <= cfg_wdata[16:0];
                ntg_pkg::CFG_VNET_CHOICE:    cfg_reg.vnet_choice <= cfg_wdata[1:0];
                ntg_pkg::CFG_STALL_LIMIT:    cfg_reg.stall_limit <= cfg_wdata[15:0];
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= ntg_pkg::in_item_t'(s_tdata[$bits(ntg_pkg::in_item_t)-1:0]);
        end
    end

    ntg_dest_sel #(
        .RADIX_LOG2 (RADIX_LOG2),
        .DEST_W     (DEST_W)
    ) u_dest_sel (
        .node_id    (cfg_reg.node_id),
        .pattern    (cfg_reg.pattern),
        .fixed_dest (cfg_reg.fixed_dest),
        .rand_dest  (item_reg.rand_dest),
        .dest       (dest)
    );

    ntg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .advance (advance),
        .flags   (flags)
    );

    assign addr_wide = SHIFT_W'(dest) << ADDR_SHIFT;

    always_comb begin
        if (cfg_reg.vnet_choice != ntg_pkg::VNET_RANDOM) begin
            vnet_sel = cfg_reg.vnet_choice;
        end else if (item_reg.rand_vnet == ntg_pkg::VNET_RANDOM) begin
            vnet_sel = ntg_pkg::VNET_WRITE;
        end else begin
            vnet_sel = item_reg.rand_vnet;
        end
    end

    always_comb begin
        m_data_next     = '0;
        m_data_next[0]  = flags.send;
        m_data_next[21] = flags.deadlock;
        if (flags.send) begin
            m_data_next[6:1]  = dest[5:0];
            m_data_next[8:7]  = vnet_sel;
            m_data_next[20:9] = addr_wide[ntg_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid_reg && !out_free |=> item_valid_reg)
        else $error("held transaction dropped from input register");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid_reg |-> s_tready)
        else $error("input stalled while input register empty");

    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[20:1] == '0))
        else $error("unsent tick carries destination fields");

    a_vnet_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[8:7] != ntg_pkg::VNET_RANDOM))
        else $error("virtual network out of range");

endmodule

### test/noc_synthetic_traffic_generator_top_tb.sv
// Self-checking testbench for the mesh-node synthetic traffic generator.
module noc_synthetic_traffic_generator_top_tb;

    localparam int RADIX_LOG2   = 3;
    localparam int ADDR_SHIFT   = 6;
    localparam int RADIX        = 1 << RADIX_LOG2;
    localparam int NODE_BITS    = 2 * RADIX_LOG2;
    localparam int NODE_MASK    = (1 << NODE_BITS) - 1;
    localparam int LATENCY      = 4;
    localparam int PHASES       = 9;
    localparam int PHASE_TICKS  = 55;

    typedef struct packed {
        logic [1:0]  pad;
        logic        deadlock;
        logic [11:0] packet_addr;
        logic [1:0]  vnet;
        logic [5:0]  dest_node;
        logic        send;
    } tick_result_t;

    typedef struct {
        bit                 is_cfg;
        ntg_pkg::cfg_idx_t  idx;
        logic [31:0]        val;
        ntg_pkg::in_item_t  item;
        bit                 typed;
        tick_result_t       want;
    } stim_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_we;
    logic [ntg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ntg_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    // rand_inject[15:0], rand_dest[21:16], rand_vnet[23:22], response_seen[24],
    // retry_pending[25], zero[31:26]
    logic [ntg_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    // send[0], dest_node[6:1], vnet[8:7], packet_addr[20:9], deadlock[21], zero[23:22]
    logic [ntg_pkg::M_TDATA_W-1:0]  m_tdata;

    ntg_pkg::cfg_t shadow;
    logic [31:0]   sent_total;
    logic [15:0]   stall_run;
    tick_result_t  pending_ticks[$];
    int            mismatches;
    bit            steady;

    noc_synthetic_traffic_generator_top #(
        .RADIX_LOG2 (RADIX_LOG2),
        .ADDR_SHIFT (ADDR_SHIFT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned route_dest(logic [5:0] rnd);
        int unsigned src;
        int unsigned x;
        int unsigned y;
        int unsigned rev;
        src = shadow.node_id & NODE_MASK;
        x   = src & (RADIX - 1);
        y   = src >> RADIX_LOG2;
        rev = 0;
        case (shadow.pattern)
            ntg_pkg::PAT_UNIFORM:    return rnd & NODE_MASK;
            ntg_pkg::PAT_COMPLEMENT: return ~src & NODE_MASK;
            ntg_pkg::PAT_REVERSE: begin
                for (int i = 0; i < NODE_BITS; i++)
                    rev |= ((src >> i) & 1) << (NODE_BITS - 1 - i);
                return rev;
            end
            ntg_pkg::PAT_ROTATION:
                return ((src >> 1) | ((src & 1) << (NODE_BITS - 1))) & NODE_MASK;
            ntg_pkg::PAT_NEIGHBOR:   return y * RADIX + ((x + 1) & (RADIX - 1));
            ntg_pkg::PAT_SHUFFLE:
                return ((src << 1) | (src >> (NODE_BITS - 1))) & NODE_MASK;
            ntg_pkg::PAT_TRANSPOSE:  return x * RADIX + y;
            default:        return y * RADIX + ((x + RADIX / 2 - 1) & (RADIX - 1));
        endcase
    endfunction

    function automatic tick_result_t predict_tick(ntg_pkg::in_item_t it);
        tick_result_t r;
        logic         go;
        int unsigned  d;
        r = '0;
        if (it.response_seen)
            stall_run = '0;
        if (it.retry_pending) begin
            if (stall_run != 16'hFFFF)
                stall_run = stall_run + 16'd1;
            r.deadlock = stall_run >= shadow.stall_limit;
        end
        go = {1'b0, it.rand_inject} < shadow.inj_threshold;
        if (!shadow.max_packets[31] && sent_total >= $unsigned(shadow.max_packets))
            go = 1'b0;
        if (!shadow.only_sender[6] && shadow.node_id != shadow.only_sender[5:0])
            go = 1'b0;
        if (go) begin
            d = shadow.fixed_dest[6] ? route_dest(it.rand_dest)
                                     : int'(shadow.fixed_dest[5:0]);
            r.send        = 1'b1;
            r.dest_node   = d[5:0];
            r.packet_addr = 12'(d << ADDR_SHIFT);
            if (shadow.vnet_choice == ntg_pkg::VNET_RANDOM)
                r.vnet = (it.rand_vnet > ntg_pkg::VNET_WRITE) ? ntg_pkg::VNET_WRITE
                                                             : it.rand_vnet;
            else
                r.vnet = shadow.vnet_choice;
            if (sent_total != 32'hFFFF_FFFF)
                sent_total = sent_total + 32'd1;
        end
        return r;
    endfunction

    function automatic stim_row_t blank_row();
        stim_row_t r;
        r = '{is_cfg: 1'b0, idx: ntg_pkg::CFG_NODE_ID, val: '0, item: '0,
              typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(ntg_pkg::cfg_idx_t idx, logic [31:0] val);
        stim_row_t r;
        r        = blank_row();
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    function automatic stim_row_t tick_row(logic [15:0] inj, logic [5:0] dst,
                                           logic [1:0] vn, logic rs, logic rp);
        stim_row_t r;
        r      = blank_row();
        r.item = '{retry_pending: rp, response_seen: rs, rand_vnet: vn,
                   rand_dest: dst, rand_inject: inj};
        return r;
    endfunction

    function automatic stim_row_t typed_row(logic [15:0] inj, logic [5:0] dst,
                                            logic [1:0] vn, logic rs, logic rp,
                                            logic snd, logic [5:0] dnode, logic [1:0] vo,
                                            logic [11:0] addr, logic dl);
        stim_row_t r;
        r       = tick_row(inj, dst, vn, rs, rp);
        r.typed = 1'b1;
        r.want  = '{pad: 2'b00, deadlock: dl, packet_addr: addr, vnet: vo,
                    dest_node: dnode, send: snd};
        return r;
    endfunction

    function automatic ntg_pkg::in_item_t random_item();
        ntg_pkg::in_item_t it;
        it.rand_inject   = 16'($urandom_range(65535));
        it.rand_dest     = 6'($urandom_range(63));
        it.rand_vnet     = 2'($urandom_range(3));
        it.response_seen = ($urandom_range(9) == 0);
        it.retry_pending = ($urandom_range(3) != 0);
        return it;
    endfunction

    task automatic settle_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic cfg_write(ntg_pkg::cfg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            ntg_pkg::CFG_NODE_ID:       shadow.node_id       = val[5:0];
            ntg_pkg::CFG_PATTERN:       shadow.pattern       = ntg_pkg::pattern_t'(val[2:0]);
            ntg_pkg::CFG_FIXED_DEST:    shadow.fixed_dest    = val[6:0];
            ntg_pkg::CFG_ONLY_SENDER:   shadow.only_sender   = val[6:0];
            ntg_pkg::CFG_MAX_PACKETS:   shadow.max_packets   = val;
            ntg_pkg::CFG_INJ_THRESHOLD: shadow.inj_threshold = val[16:0];
            ntg_pkg::CFG_VNET_CHOICE:   shadow.vnet_choice   = val[1:0];
            ntg_pkg::CFG_STALL_LIMIT:   shadow.stall_limit   = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_tick(ntg_pkg::in_item_t it, bit typed, tick_result_t want);
        tick_result_t pred;
        while (!steady && $urandom_range(99) < 12) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(ntg_pkg::S_TDATA_W - $bits(ntg_pkg::in_item_t)){1'b0}}, it};
        do
            @(posedge aclk);
        while (!s_tready);
        pred = predict_tick(it);
        pending_ticks.push_back(typed ? want : pred);
    endtask

    task automatic report_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 12);

    always @(posedge aclk) begin
        tick_result_t got;
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = tick_result_t'(m_tdata);
            if (pending_ticks.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none actual %h", $time, got);
            end else begin
                want = pending_ticks.pop_front();
                report_field("send", want.send, got.send);
                report_field("dest_node", want.dest_node, got.dest_node);
                report_field("vnet", want.vnet, got.vnet);
                report_field("packet_addr", want.packet_addr, got.packet_addr);
                report_field("deadlock", want.deadlock, got.deadlock);
                report_field("pad", want.pad, got.pad);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        stim_row_t    dir_tbl[$];
        logic [31:0]  v;
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        steady     = 1'b0;
        mismatches = 0;
        sent_total = '0;
        stall_run  = '0;
        shadow     = '{node_id: 6'd0, pattern: ntg_pkg::PAT_UNIFORM, fixed_dest: -7'sd1,
                       only_sender: -7'sd1, max_packets: -32'sd1, inj_threshold: 17'd6554,
                       vnet_choice: ntg_pkg::VNET_RANDOM, stall_limit: 16'd5000};

        dir_tbl = {
            typed_row(16'd0, 6'd63, 2'd3, 1'b0, 1'b0, 1'b1, 6'd63, 2'd2, 12'hFC0, 1'b0),
            typed_row(16'hFFFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            typed_row(16'd6553, 6'd0, 2'd0, 1'b0, 1'b0, 1'b1, 6'd0, 2'd0, 12'h0, 1'b0),
            typed_row(16'd6554, 6'd21, 2'd1, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            cfg_row(ntg_pkg::CFG_NODE_ID, 32'd63),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_COMPLEMENT),
            tick_row(16'd100, 6'd0, 2'd1, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_REVERSE),
            tick_row(16'd100, 6'd5, 2'd0, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_ROTATION),
            tick_row(16'd100, 6'd9, 2'd2, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_NEIGHBOR),
            tick_row(16'd100, 6'd1, 2'd3, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_SHUFFLE),
            tick_row(16'd100, 6'd2, 2'd0, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_TRANSPOSE),
            tick_row(16'd100, 6'd3, 2'd1, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_TORNADO),
            tick_row(16'd100, 6'd4, 2'd2, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_FIXED_DEST, 32'd63),
            typed_row(16'd0, 6'd5, 2'd2, 1'b0, 1'b0, 1'b1, 6'd63, 2'd2, 12'hFC0, 1'b0),
            cfg_row(ntg_pkg::CFG_FIXED_DEST, 32'h40),
            tick_row(16'd0, 6'd7, 2'd3, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_ONLY_SENDER, 32'd5),
            typed_row(16'd0, 6'd7, 2'd0, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            cfg_row(ntg_pkg::CFG_ONLY_SENDER, 32'd63),
            tick_row(16'd0, 6'd8, 2'd1, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_ONLY_SENDER, 32'h7F),
            cfg_row(ntg_pkg::CFG_MAX_PACKETS, 32'd0),
            typed_row(16'd0, 6'd8, 2'd1, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            cfg_row(ntg_pkg::CFG_MAX_PACKETS, 32'h7FFF_FFFF),
            tick_row(16'd1, 6'd9, 2'd2, 1'b0, 1'b0),
            cfg_row(ntg_pkg::CFG_INJ_THRESHOLD, 32'd65536),
            cfg_row(ntg_pkg::CFG_PATTERN, ntg_pkg::PAT_UNIFORM),
            typed_row(16'hFFFF, 6'd42, 2'd2, 1'b0, 1'b0, 1'b1, 6'd42, 2'd2, 12'hA80, 1'b0),
            cfg_row(ntg_pkg::CFG_INJ_THRESHOLD, 32'd0),
            typed_row(16'd0, 6'd42, 2'd2, 1'b0, 1'b0, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            cfg_row(ntg_pkg::CFG_INJ_THRESHOLD, 32'd6554),
            cfg_row(ntg_pkg::CFG_VNET_CHOICE, 32'd1),
            typed_row(16'd0, 6'd10, 2'd3, 1'b0, 1'b0, 1'b1, 6'd10, 2'd1, 12'h280, 1'b0),
            cfg_row(ntg_pkg::CFG_STALL_LIMIT, 32'd1),
            typed_row(16'hFFFF, 6'd0, 2'd0, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0, 12'h0, 1'b1),
            typed_row(16'hFFFF, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 6'd0, 2'd0, 12'h0, 1'b1),
            typed_row(16'hFFFF, 6'd0, 2'd0, 1'b1, 1'b0, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0),
            cfg_row(ntg_pkg::CFG_STALL_LIMIT, 32'd0),
            typed_row(16'hFFFF, 6'd0, 2'd0, 1'b1, 1'b1, 1'b0, 6'd0, 2'd0, 12'h0, 1'b1),
            cfg_row(ntg_pkg::CFG_STALL_LIMIT, 32'd65535),
            typed_row(16'hFFFF, 6'd0, 2'd0, 1'b0, 1'b1, 1'b0, 6'd0, 2'd0, 12'h0, 1'b0)
        };

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].is_cfg) begin
                settle_idle();
                cfg_write(dir_tbl[i].idx, dir_tbl[i].val);
            end else begin
                send_tick(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle_idle();
            steady = (ph == PHASES / 2);
            cfg_write(ntg_pkg::CFG_NODE_ID, $urandom_range(63));
            cfg_write(ntg_pkg::CFG_PATTERN, $urandom_range(7));
            case ($urandom_range(3))
                0:       v = $urandom_range(127);
                1:       v = $urandom_range(63);
                default: v = 32'h7F;
            endcase
            cfg_write(ntg_pkg::CFG_FIXED_DEST, v);
            case ($urandom_range(3))
                0:       v = shadow.node_id;
                1:       v = $urandom_range(127);
                default: v = 32'h7F;
            endcase
            cfg_write(ntg_pkg::CFG_ONLY_SENDER, v);
            case ($urandom_range(5))
                0:       v = sent_total + $urandom_range(40);
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h8000_0000 | $urandom;
                default: v = 32'hFFFF_FFFF;
            endcase
            cfg_write(ntg_pkg::CFG_MAX_PACKETS, v);
            case ($urandom_range(7))
                0:       v = 32'd0;
                1:       v = 32'd65536;
                2:       v = 32'h1FFFF;
                default: v = $urandom_range(65535);
            endcase
            cfg_write(ntg_pkg::CFG_INJ_THRESHOLD, v);
            cfg_write(ntg_pkg::CFG_VNET_CHOICE, $urandom_range(3));
            case ($urandom_range(3))
                0:       v = $urandom_range(3);
                1:       v = 32'd65535;
                default: v = $urandom_range(40, 1);
            endcase
            cfg_write(ntg_pkg::CFG_STALL_LIMIT, v);
            repeat (PHASE_TICKS) send_tick(random_item(), 1'b0, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### noc_synthetic_traffic_generator_top.f
rtl/core/ntg_pkg.sv
rtl/core/ntg_dest_sel.sv
rtl/core/ntg_ctrl.sv
rtl/core/noc_synthetic_traffic_generator_top.sv
test/noc_synthetic_traffic_generator_top_tb.sv
